// ----- rtl/core/trl_pkg.sv -----
// ----------------------------------------------------------------------------
// trl_pkg: shared definitions for the table-to-grid linear resampler
// Field widths, register indexes, status codes and divider handshake types.
// ----------------------------------------------------------------------------
package trl_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam int S_TDATA_W  = 80;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_CELLS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_AT_CELLS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD       = 2'd3;

    localparam logic [31:0] GRID_STEP_RST  = 32'd65536;
    localparam logic [15:0] GRID_CELLS_RST = 16'd500;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_BELOW = 2'd1;
    localparam logic [1:0] STATUS_PAST  = 2'd2;
    localparam logic [1:0] STATUS_BAD   = 2'd3;

    localparam int DIV_W     = 33;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 6'd32;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] divisor;
        logic [DIV_W-1:0] rem_init;
        logic [DIV_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/core/table_to_grid_linear_resampler.sv -----
// ----------------------------------------------------------------------------
// table_to_grid_linear_resampler: tabulated curve resampled onto a grid
// Loads (x, y) points, answers grid index queries by linear interpolation.
// ----------------------------------------------------------------------------
// Input items arrive on s_*: s_tuser[0] selects load (0) or query (1). A load
// writes one point (s_tuser[1] restarts the table at entry zero) and gives no
// output item. A query gives one output item on m_*: the Q16.16 value
// clamped at zero and a status code.
// A query runs through setup, the table search, the segment fetch, the
// product, the divider and the output register. Search steps follow the
// table read port: about log2(points) when x was loaded ascending, up to
// points-1 otherwise.
// Out-of-range, below-threshold and zero-width cases finish early.
// One shared 32x32 multiplier forms all grid points and the segment product;
// one restoring divider forms the interpolation quotient.
// s_tready is high only while the block is idle; the next item is accepted
// while a finished result waits in the output register. A stalled receiver
// holds the result; a following query then waits at its last cycle.
// Reset (aresetn low, synchronous) restores the configuration registers,
// empties the table and drops any pending result. Config writes on cfg_*
// take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module table_to_grid_linear_resampler
    import trl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // point_x, point_y, grid_index
    input  logic [S_TUSER_W-1:0]  s_tuser,   // mode, first_point
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // value, zero pad
    output logic [M_TUSER_W-1:0]  m_tuser,   // status
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MUL_LAST = 4'd1;
    localparam logic [3:0] ST_MUL_J    = 4'd2;
    localparam logic [3:0] ST_THR      = 4'd3;
    localparam logic [3:0] ST_SRCH_RD  = 4'd4;
    localparam logic [3:0] ST_SRCH_CMP = 4'd5;
    localparam logic [3:0] ST_FETCH_HI = 4'd6;
    localparam logic [3:0] ST_FETCH_LO = 4'd7;
    localparam logic [3:0] ST_PREP     = 4'd8;
    localparam logic [3:0] ST_PROD     = 4'd9;
    localparam logic [3:0] ST_DIV      = 4'd10;
    localparam logic [3:0] ST_FIN      = 4'd11;

    localparam logic signed [34:0] VALUE_MAX = 35'sd2147483647;

    function automatic logic [30:0] clamp_val(input logic signed [34:0] r);
        logic [30:0] v;
        if (r < 0) begin
            v = '0;
        end else if (r > VALUE_MAX) begin
            v = '1;
        end else begin
            v = r[30:0];
        end
        return v;
    endfunction

    // configuration
    logic [31:0] grid_step_reg;
    logic [15:0] grid_cells_reg;
    logic        at_cells_reg;
    logic [31:0] threshold_reg;

    // input fields
    logic        in_mode;
    logic        in_first;
    logic [31:0] in_x;
    logic [31:0] in_y;
    logic [15:0] in_j;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          sorted_reg, sorted_next;
    logic [31:0]   last_x_reg, last_x_next;
    logic [15:0]   j_reg, j_next;
    logic [49:0]   glast2_reg, glast2_next;
    logic [49:0]   g2_reg, g2_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [31:0]   x2_reg, x2_next;
    logic [31:0]   y2_reg, y2_next;
    logic [31:0]   y1_reg, y1_next;
    logic [31:0]   a_reg, a_next;
    logic          n32_reg, n32_next;
    logic          neg_reg, neg_next;
    logic [32:0]   d2_reg, d2_next;
    logic [63:0]   prod_reg, prod_next;
    logic [30:0]   res_value_reg, res_value_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [30:0]   m_value_reg, m_value_next;
    logic [1:0]    m_status_reg, m_status_next;

    // table port
    logic          tbl_wr_en;
    logic [AW-1:0] tbl_wr_addr;
    logic [AW-1:0] tbl_rd_addr;
    logic [31:0]   rd_x;
    logic [31:0]   rd_y;

    // shared multiplier and divider
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    // scratch
    logic                  accept;
    logic [16:0]           npts;
    logic [15:0]           npts_m1;
    logic [49:0]           half_step;
    logic [CW:0]           lo_hi_sum;
    logic [CW-1:0]         probe;
    logic [CW-1:0]         load_base;
    logic signed [50:0]    ndiff;
    logic signed [32:0]    dy;
    logic [50:0]           n_abs;
    logic [32:0]           a_abs;
    logic [64:0]           full_prod;
    logic signed [34:0]    sum_res;

    assign in_mode  = s_tuser[0];
    assign in_first = s_tuser[1];
    assign in_x     = s_tdata[31:0];
    assign in_y     = s_tdata[63:32];
    assign in_j     = s_tdata[79:64];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign npts      = at_cells_reg ? {1'b0, grid_cells_reg} : {1'b0, grid_cells_reg} + 17'd1;
    assign npts_m1   = at_cells_reg ? grid_cells_reg - 16'd1 : grid_cells_reg;
    assign half_step = at_cells_reg ? {18'd0, grid_step_reg} : '0;
    assign lo_hi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign probe     = sorted_reg ? lo_hi_sum[CW:1] : lo_reg;
    assign load_base = in_first ? '0 : count_reg;

    assign ndiff     = $signed({1'b0, g2_reg}) - $signed({18'd0, rd_x, 1'b0});
    assign dy        = $signed({y2_reg[31], y2_reg}) - $signed({rd_y[31], rd_y});
    assign n_abs     = ndiff[50] ? 51'(-ndiff) : 51'(ndiff);
    assign a_abs     = dy[32] ? 33'(-dy) : 33'(dy);
    assign full_prod = {1'b0, prod_reg} + (n32_reg ? {1'b0, a_reg, 32'd0} : 65'd0);
    assign sum_res   = neg_reg
                     ? $signed({{3{y1_reg[31]}}, y1_reg}) - $signed({2'b0, div_rsp.quotient})
                     : $signed({{3{y1_reg[31]}}, y1_reg}) + $signed({2'b0, div_rsp.quotient});

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        sorted_next     = sorted_reg;
        last_x_next     = last_x_reg;
        j_next          = j_reg;
        glast2_next     = glast2_reg;
        g2_next         = g2_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        x2_next         = x2_reg;
        y2_next         = y2_reg;
        y1_next         = y1_reg;
        a_next          = a_reg;
        n32_next        = n32_reg;
        neg_next        = neg_reg;
        d2_next         = d2_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_value_next    = m_value_reg;
        m_status_next   = m_status_reg;
        tbl_wr_en       = 1'b0;
        tbl_wr_addr     = load_base[AW-1:0];
        tbl_rd_addr     = probe[AW-1:0];
        mul_a           = '0;
        mul_b           = '0;
        div_req         = '0;
        div_req.divisor  = d2_reg;
        div_req.rem_init = {1'b0, full_prod[64:33]};
        div_req.dividend = full_prod[32:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_mode == MODE_LOAD) begin
                        if (load_base < CW'(TABLE_DEPTH)) begin
                            tbl_wr_en   = 1'b1;
                            count_next  = load_base + 1'b1;
                            sorted_next = (load_base == '0)
                                          || (sorted_reg && (in_x >= last_x_reg));
                            last_x_next = in_x;
                        end
                    end else begin
                        j_next = in_j;
                        if ({1'b0, in_j} >= npts || count_reg < CW'(2)) begin
                            res_value_next  = '0;
                            res_status_next = STATUS_BAD;
                            state_next      = ST_FIN;
                        end else begin
                            state_next = ST_MUL_LAST;
                        end
                    end
                end
            end
            ST_MUL_LAST: begin
                mul_a      = {16'd0, npts_m1};
                mul_b      = grid_step_reg;
                state_next = ST_MUL_J;
            end
            ST_MUL_J: begin
                glast2_next = {prod_reg[48:0], 1'b0} + half_step;
                mul_a       = {16'd0, j_reg};
                mul_b       = grid_step_reg;
                state_next  = ST_THR;
            end
            ST_THR: begin
                g2_next = {prod_reg[48:0], 1'b0} + half_step;
                lo_next = CW'(1);
                hi_next = count_reg;
                if ({17'd0, threshold_reg, 1'b0} >= glast2_reg
                    || prod_reg < {32'd0, threshold_reg}) begin
                    res_value_next  = '0;
                    res_status_next = STATUS_BELOW;
                    state_next      = ST_FIN;
                end else begin
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD: begin
                if (lo_reg == hi_reg) begin
                    if (lo_reg < count_reg) begin
                        state_next = ST_FETCH_HI;
                    end else begin
                        res_value_next  = '0;
                        res_status_next = STATUS_PAST;
                        state_next      = ST_FIN;
                    end
                end else begin
                    state_next = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                if ({17'd0, rd_x, 1'b0} >= g2_reg) begin
                    hi_next = probe;
                end else begin
                    lo_next = probe + 1'b1;
                end
                state_next = ST_SRCH_RD;
            end
            ST_FETCH_HI: begin
                tbl_rd_addr = lo_reg[AW-1:0];
                state_next  = ST_FETCH_LO;
            end
            ST_FETCH_LO: begin
                x2_next     = rd_x;
                y2_next     = rd_y;
                tbl_rd_addr = AW'(lo_reg - 1'b1);
                state_next  = ST_PREP;
            end
            ST_PREP: begin
                y1_next  = rd_y;
                a_next   = a_abs[31:0];
                n32_next = n_abs[32];
                neg_next = dy[32] ^ ndiff[50];
                d2_next  = {x2_reg - rd_x, 1'b0};
                mul_a    = a_abs[31:0];
                mul_b    = n_abs[31:0];
                if (x2_reg <= rd_x) begin
                    res_value_next  = clamp_val({{3{y2_reg[31]}}, y2_reg});
                    res_status_next = STATUS_OK;
                    state_next      = ST_FIN;
                end else begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                res_status_next = STATUS_OK;
                if ({1'b0, full_prod[64:33]} >= d2_reg) begin
                    res_value_next = neg_reg ? '0 : '1;
                    state_next     = ST_FIN;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    res_value_next = clamp_val(sum_res);
                    state_next     = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_value_next  = res_value_reg;
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            sorted_reg     <= 1'b1;
            m_tvalid_reg   <= 1'b0;
            grid_step_reg  <= GRID_STEP_RST;
            grid_cells_reg <= GRID_CELLS_RST;
            at_cells_reg   <= 1'b0;
            threshold_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            sorted_reg   <= sorted_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_GRID_STEP:       grid_step_reg  <= cfg_data[31:0];
                    REG_GRID_CELLS:      grid_cells_reg <= cfg_data[15:0];
                    REG_SAMPLE_AT_CELLS: at_cells_reg   <= cfg_data[0];
                    REG_THRESHOLD:       threshold_reg  <= cfg_data[31:0];
                    default: ;
                endcase
            end
        end
        last_x_reg     <= last_x_next;
        j_reg          <= j_next;
        glast2_reg     <= glast2_next;
        g2_reg         <= g2_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        x2_reg         <= x2_next;
        y2_reg         <= y2_next;
        y1_reg         <= y1_next;
        a_reg          <= a_next;
        n32_reg        <= n32_next;
        neg_reg        <= neg_next;
        d2_reg         <= d2_next;
        prod_reg       <= prod_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
    end

    trl_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_x    (in_x),
        .wr_y    (in_y),
        .rd_addr (tbl_rd_addr),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    trl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_value_reg};
    assign m_tuser  = m_status_reg;

endmodule

// ----- rtl/core/trl_table.sv -----
// ----------------------------------------------------------------------------
// trl_table: point table storage
// Abscissa and ordinate memories, one write port and one registered read port.
// ----------------------------------------------------------------------------
module trl_table
    import trl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_x,
    input  logic [31:0]   wr_y,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_x,
    output logic [31:0]   rd_y
);

    logic [31:0] x_mem [TABLE_DEPTH];
    logic [31:0] y_mem [TABLE_DEPTH];
    logic [31:0] rd_x_reg;
    logic [31:0] rd_y_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
        rd_x_reg <= x_mem[rd_addr];
        rd_y_reg <= y_mem[rd_addr];
    end

    assign rd_x = rd_x_reg;
    assign rd_y = rd_y_reg;

endmodule

// ----- rtl/core/trl_div.sv -----
// ----------------------------------------------------------------------------
// trl_div: iterative restoring divider
// One quotient bit per cycle; remainder is preloaded below the divisor.
// ----------------------------------------------------------------------------
module trl_div
    import trl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_W:0]       trial;

    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_W-1]} - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.rem_init;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DIV_W]) begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- rtl/core/trl_chk.sv -----
// ----------------------------------------------------------------------------
// trl_chk: port checker for the table-to-grid linear resampler
// Watches the stream and reset behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module trl_chk
    import trl_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_OK |-> m_tdata == '0)
        else $error("nonzero value with a non-interpolated status");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == MODE_QUERY |=> !s_tready)
        else $error("ready right after a query item");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind table_to_grid_linear_resampler trl_chk u_trl_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/table_to_grid_linear_resampler_test.sv -----
// ----------------------------------------------------------------------------
// table_to_grid_linear_resampler_test: self-checking bench for the resampler
// Loads tabulated curves and sends grid queries under random stalls on both
// stream sides. A scoreboard model of the table and registers predicts the
// value and status of every query. Each result is checked in order.
// ----------------------------------------------------------------------------
module table_to_grid_linear_resampler_test;
    import trl_pkg::*;

    localparam int      TABLE_SIZE    = DEFAULT_TABLE_DEPTH;
    localparam int      CYCLE_LIMIT   = 1000000;
    localparam int      TOTAL_ITEMS   = 1250;
    localparam longint  VALUE_TOP     = 64'h0000_0000_7FFF_FFFF;

    typedef struct packed {
        logic [30:0] value;
        logic [1:0]  status;
    } sample_t;

    class resampler_scoreboard;
        logic [63:0] step;
        logic [63:0] cells;
        bit          at_cells;
        logic [63:0] thr;
        logic [31:0] tab_x [TABLE_SIZE];
        int          tab_y [TABLE_SIZE];
        int          loaded;
        sample_t     expected_samples [$];
        int          failures;
        int          loads;
        int          queries;
        int          status_seen [4];

        function new();
            step     = 64'(GRID_STEP_RST);
            cells    = 64'(GRID_CELLS_RST);
            at_cells = 1'b0;
            thr      = '0;
            loaded   = 0;
            failures = 0;
            loads    = 0;
            queries  = 0;
            status_seen = '{0, 0, 0, 0};
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GRID_STEP:       step = 64'(data);
                REG_GRID_CELLS:      cells = 64'(data[15:0]);
                REG_SAMPLE_AT_CELLS: at_cells = data[0];
                REG_THRESHOLD:       thr = 64'(data);
                default: ;
            endcase
        endfunction

        // twice the grid point, one extra fraction bit
        function logic [63:0] grid_point2(logic [63:0] j);
            return 64'd2 * j * step + (at_cells ? step : 64'd0);
        endfunction

        function sample_t resample_point(logic [15:0] gj);
            sample_t     s;
            logic [63:0] npts, j, g2, a, n, d2;
            logic [127:0] quot;
            longint      y_lo, y_hi, dy, ndiff, res, lift;
            int          i;
            s.value  = '0;
            s.status = STATUS_BAD;
            j    = 64'(gj);
            npts = at_cells ? cells : cells + 64'd1;
            if (j >= npts || loaded < 2)
                return s;
            s.status = STATUS_BELOW;
            if (64'd2 * thr >= grid_point2(npts - 64'd1) || j * step < thr)
                return s;
            g2 = grid_point2(j);
            for (i = 1; i < loaded; i++)
                if ({31'b0, tab_x[i], 1'b0} >= g2)
                    break;
            s.status = STATUS_PAST;
            if (i >= loaded)
                return s;
            y_lo = longint'(tab_y[i-1]);
            y_hi = longint'(tab_y[i]);
            if (tab_x[i] <= tab_x[i-1]) begin
                res = y_hi;
            end else begin
                dy    = y_hi - y_lo;
                ndiff = longint'(g2) - 2 * longint'({32'b0, tab_x[i-1]});
                a     = (dy < 0) ? -dy : dy;
                n     = (ndiff < 0) ? -ndiff : ndiff;
                d2    = {31'b0, tab_x[i] - tab_x[i-1], 1'b0};
                quot  = ({64'b0, a} * {64'b0, n}) / {64'b0, d2};
                if (quot[127:62] != '0)
                    quot = 128'd1 << 62;
                lift = longint'(quot[63:0]);
                res  = ((dy < 0) != (ndiff < 0)) ? y_lo - lift : y_lo + lift;
            end
            if (res < 0)
                res = 0;
            if (res > VALUE_TOP)
                res = VALUE_TOP;
            s.value  = res[30:0];
            s.status = STATUS_OK;
            return s;
        endfunction

        function void note_item(logic mode, logic first, logic [31:0] px, logic [31:0] py,
                                logic [15:0] gj);
            if (mode == MODE_LOAD) begin
                loads++;
                if (first)
                    loaded = 0;
                if (loaded < TABLE_SIZE) begin
                    tab_x[loaded] = px;
                    tab_y[loaded] = py;
                    loaded++;
                end
            end else begin
                queries++;
                expected_samples.push_back(resample_point(gj));
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
            sample_t want;
            if (expected_samples.size() == 0) begin
                failures++;
                $display("%0t unexpected result: value %h status %0d", $time, data[30:0], user);
                return;
            end
            want = expected_samples.pop_front();
            status_seen[want.status]++;
            if (data[30:0] !== want.value) begin
                failures++;
                $display("%0t value mismatch: expected %h actual %h",
                         $time, want.value, data[30:0]);
            end
            if (user !== want.status) begin
                failures++;
                $display("%0t status mismatch: expected %0d actual %0d",
                         $time, want.status, user);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // point_x, point_y, grid_index
    logic [S_TUSER_W-1:0]  s_tuser;    // mode, first_point
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;    // value, zero pad
    logic [M_TUSER_W-1:0]  m_tuser;    // status
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    resampler_scoreboard curve_board = new();

    int sender_max   = 16;
    int sink_max     = 16;
    int hold_request = 0;
    int items_sent   = 0;
    int settings     = 0;
    int cycle_count  = 0;

    table_to_grid_linear_resampler DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                curve_board.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                curve_board.note_item(s_tuser[0], s_tuser[1], s_tdata[31:0], s_tdata[63:32],
                                      s_tdata[79:64]);
        end
    end

    initial begin : sink
        int stall;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end else begin
                stall = $urandom_range(0, sink_max);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    task automatic offer(logic mode, logic first, logic [31:0] px, logic [31:0] py,
                         logic [15:0] gj);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {gj, py, px};
        s_tuser  <= {first, mode};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        gap = $urandom_range(0, sender_max);
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic load(logic first, logic [31:0] px, logic [31:0] py);
        offer(MODE_LOAD, first, px, py, 16'($urandom));
    endtask

    task automatic query(logic [15:0] gj);
        offer(MODE_QUERY, 1'($urandom), $urandom, $urandom, gj);
    endtask

    // drop valid, wait out every pending result, let the block settle
    task automatic end_burst();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (curve_board.expected_samples.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk) cfg_wr_en <= 1'b0;
        curve_board.set_reg(idx, data);
    endtask

    task automatic set_config(logic [31:0] step, logic [15:0] cells, logic at_cells,
                              logic [31:0] thr);
        write_reg(REG_GRID_STEP, step);
        write_reg(REG_GRID_CELLS, {16'b0, cells});
        write_reg(REG_SAMPLE_AT_CELLS, {31'b0, at_cells});
        write_reg(REG_THRESHOLD, thr);
        settings++;
    endtask

    function automatic logic [31:0] draw_ordinate();
        if ($urandom_range(0, 1))
            return $urandom;
        return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endfunction

    task automatic directed_items();
        query(16'd0);
        load(1'b1, 32'h0001_0000, 32'h8000_0000);
        query(16'd1);
        load(1'b0, 32'h0001_0000, 32'h7FFF_FFFF);
        query(16'd1);
        load(1'b0, 32'h0005_0000, 32'hFFFF_0000);
        query(16'd3);
        query(16'd6);
        query(16'd500);
        query(16'd501);
        query(16'hFFFF);
        load(1'b0, 32'hFFFF_FFFF, 32'h0002_0000);
        query(16'd500);
        // steep segment above the grid point: extrapolation saturates
        load(1'b1, 32'h0010_0000, 32'h7FFF_0000);
        load(1'b0, 32'h0010_0001, 32'h0000_0000);
        query(16'd0);
        // extrapolation that goes negative and clamps
        load(1'b1, 32'h0003_0000, 32'h0064_0000);
        load(1'b0, 32'h0004_0000, 32'h00C8_0000);
        query(16'd1);
        end_burst();
        set_config(32'h0000_8000, 16'd500, 1'b1, 32'h0001_8000);
        query(16'd3);
        query(16'd2);
        end_burst();
        set_config(32'h0000_8000, 16'd500, 1'b1, 32'hFFFF_FFFF);
        query(16'd0);
        end_burst();
        set_config(32'h0000_0000, 16'd500, 1'b0, 32'h0000_0000);
        query(16'd7);
        end_burst();
        set_config(32'h0001_0000, 16'd0, 1'b1, 32'h0000_0000);
        query(16'd0);
        end_burst();
    endtask

    // fill past the table depth with ascending x, then query across it
    task automatic fill_table();
        int k;
        set_config(32'h0001_0000, 16'd1100, 1'b0, $urandom_range(0, 32'h0008_0000));
        sender_max = 0;
        for (k = 0; k < TABLE_SIZE + 6; k++)
            load(k == 0, (32'(k) << 16) + $urandom_range(0, 16'hFFFF), draw_ordinate());
        sender_max = 16;
        for (k = 0; k < 20; k++)
            query(16'($urandom_range(0, 1101)));
        end_burst();
    endtask

    task automatic run_phase(int phase_no);
        logic [63:0] npts, span64, xa, inc_max;
        logic [31:0] step, thr, span;
        logic [15:0] cells, gj, jtop;
        logic        at_cells, ordered;
        int          n_points, n_queries, k, pick;
        case ($urandom_range(0, 9))
            0:       step = 32'd1;
            1:       step = 32'hFFFF_FFFF;
            2:       step = $urandom;
            3, 4:    step = 32'h0001_0000;
            default: step = $urandom_range(1, 32'h0004_0000);
        endcase
        case ($urandom_range(0, 7))
            0:       cells = 16'd1;
            1:       cells = 16'hFFFF;
            2:       cells = 16'($urandom_range(1, 16'hFFFF));
            default: cells = 16'($urandom_range(1, 40));
        endcase
        at_cells = 1'($urandom_range(0, 1));
        npts   = at_cells ? {48'b0, cells} : {48'b0, cells} + 64'd1;
        span64 = npts * {32'b0, step};
        span   = (span64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span64[31:0];
        case ($urandom_range(0, 9))
            0:          thr = 32'hFFFF_FFFF;
            1:          thr = $urandom;
            2, 3, 4, 5: thr = '0;
            default:    thr = $urandom_range(0, span / 2);
        endcase
        set_config(step, cells, at_cells, thr);
        sender_max = $urandom_range(0, 3) == 0 ? 0 : 16;
        sink_max   = $urandom_range(0, 3) == 0 ? 0 : 16;

        pick = $urandom_range(0, 19);
        n_points = (pick < 2) ? pick : $urandom_range(2, 12);
        ordered  = $urandom_range(0, 6) != 0;
        xa       = 64'($urandom_range(0, span / 4));
        inc_max  = (64'd2 * span) / (n_points + 1);
        if (inc_max > 64'hFFFF_FFFF)
            inc_max = 64'hFFFF_FFFF;
        for (k = 0; k < n_points; k++) begin
            if (ordered) begin
                load(k == 0, (xa > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : xa[31:0], draw_ordinate());
                if ($urandom_range(0, 9) != 0)
                    xa = xa + 64'($urandom_range(0, inc_max[31:0]));
            end else begin
                load(k == 0, $urandom_range(0, span), draw_ordinate());
            end
        end

        if (phase_no == 1) begin
            hold_request = 400;
            sender_max   = 0;
        end
        jtop = (npts + 64'd1 > 64'hFFFF) ? 16'hFFFF : 16'(npts + 64'd1);
        n_queries = $urandom_range(8, 30);
        for (k = 0; k < n_queries; k++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                load($urandom_range(0, 3) == 0, $urandom_range(0, span), draw_ordinate());
            end else begin
                if (pick < 15)
                    gj = 16'($urandom_range(0, jtop));
                else if (pick < 18)
                    gj = 16'($urandom);
                else
                    gj = 16'(npts - 64'd1 + 64'($urandom_range(0, 1)));
                query(gj);
            end
        end
        end_burst();
    endtask

    initial begin
        int phase_no;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        directed_items();
        fill_table();
        phase_no = 0;
        while (items_sent < TOTAL_ITEMS) begin
            run_phase(phase_no);
            phase_no++;
        end

        end_burst();
        repeat (100) @(posedge aclk);
        $display("Covered %0d loads and %0d queries over %0d register settings.",
                 curve_board.loads, curve_board.queries, settings);
        $display("Results interpolated %0d, below threshold %0d, past end %0d, rejected %0d.",
                 curve_board.status_seen[STATUS_OK], curve_board.status_seen[STATUS_BELOW],
                 curve_board.status_seen[STATUS_PAST], curve_board.status_seen[STATUS_BAD]);
        if (curve_board.expected_samples.size() != 0)
            $display("%0d results never arrived", curve_board.expected_samples.size());
        if (curve_board.failures == 0 && curve_board.expected_samples.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
